@@ rtl/mzec_pkg.sv @@
package mzec_pkg;

   localparam int WIN_MAX = 16;
   localparam int IDX_W   = $clog2(WIN_MAX);
   localparam int FILL_W  = IDX_W + 1;
   localparam int SMP_W   = 32;
   localparam int MA_W    = 72;
   localparam int MB_W    = 40;
   localparam int MP_W    = 112;
   localparam int DIG_W   = 4;
   localparam int LVL_W   = 48;

   localparam logic [2:0] REG_TP_WIN  = 3'd0;
   localparam logic [2:0] REG_RTT_WIN = 3'd1;
   localparam logic [2:0] REG_JIT_WIN = 3'd2;
   localparam logic [2:0] REG_Z_LIMIT = 3'd3;
   localparam logic [2:0] REG_TP_GAIN = 3'd4;
   localparam logic [2:0] REG_RTT_GAIN = 3'd5;
   localparam logic [2:0] REG_JIT_GAIN = 3'd6;

   typedef struct packed {
      logic             start;
      logic [MA_W-1:0]  a;
      logic [MB_W-1:0]  b;
      logic [DIG_W-1:0] ndig;
   } mul_req_type;

   typedef struct packed {
      logic             clear;
      logic             insert;
      logic [SMP_W-1:0] x;
   } sort_req_type;

endpackage

@@ rtl/mzec_mul.sv @@
module mzec_mul
   import mzec_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  mul_req_type      req,
   output logic             done,
   output logic [MP_W-1:0]  prod
);

   logic                    run_ff;
   logic                    done_ff;
   logic [DIG_W-1:0]        cnt_ff;
   logic [MA_W-1:0]         a_ff;
   logic [MB_W-1:0]         b_ff;
   logic [MP_W-1:0]         acc_ff;
   logic [MA_W+DIG_W-1:0]   pp;

   // radix-16 digit per cycle, most significant digit first
   assign pp = {{DIG_W{1'b0}}, a_ff} * {{MA_W{1'b0}}, b_ff[MB_W-1 -: DIG_W]};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else if (req.start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= req.ndig;
         a_ff    <= req.a;
         b_ff    <= req.b;
         acc_ff  <= '0;
      end else if (run_ff) begin
         acc_ff  <= {acc_ff[MP_W-DIG_W-1:0], {DIG_W{1'b0}}}
                    + {{(MP_W-MA_W-DIG_W){1'b0}}, pp};
         b_ff    <= {b_ff[MB_W-DIG_W-1:0], {DIG_W{1'b0}}};
         cnt_ff  <= cnt_ff - 1'b1;
         if (cnt_ff == DIG_W'(1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

@@ rtl/mzec_sort.sv @@
module mzec_sort
   import mzec_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  sort_req_type      req,
   input  logic [FILL_W-1:0] n,
   output logic [SMP_W:0]    twice_median
);

   logic [SMP_W-1:0]  lane_ff [WIN_MAX];
   logic [FILL_W-1:0] cnt_ff;
   logic [WIN_MAX-1:0] gt;
   logic [IDX_W-1:0]  mid;
   logic [IDX_W-1:0]  mid_lo;

   always_comb begin
      for (int k = 0; k < WIN_MAX; k++) begin
         gt[k] = (FILL_W'(k) < cnt_ff) && (lane_ff[k] > req.x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || req.clear) begin
         cnt_ff <= '0;
      end else if (req.insert) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // shift larger entries up by one, drop the new value into the gap
   always_ff @(posedge clock) begin
      if (req.insert) begin
         for (int k = 0; k < WIN_MAX; k++) begin
            if (k > 0 && gt[(k > 0) ? k-1 : 0]) begin
               lane_ff[k] <= lane_ff[(k > 0) ? k-1 : 0];
            end else if (gt[k] || FILL_W'(k) == cnt_ff) begin
               lane_ff[k] <= req.x;
            end
         end
      end
   end

   assign mid    = n[FILL_W-1:1] == FILL_W'(WIN_MAX/2) ? IDX_W'(WIN_MAX/2)
                                                      : n[IDX_W:1];
   assign mid_lo = mid - 1'b1;

   always_comb begin
      if (n[0]) begin
         twice_median = {lane_ff[mid], 1'b0};
      end else begin
         twice_median = {1'b0, lane_ff[mid_lo]} + {1'b0, lane_ff[mid]};
      end
   end

endmodule

@@ rtl/median_zscore_ewma_conditioner.sv @@
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_stall | throughput, rtt, jitter samples
// rsp     | out       | rsp_valid/rsp_stall | smoothed levels, rejected flags
// csr     | in        | csr_wr_en           | csr_index, csr_data
// Time per item grows with each channel's window fill after the push (windows hold
// up to 16 entries); the shared radix-16 multiplier sets it.
// Reset is synchronous: windows empty, levels zero, registers at defaults.
// req_stall stays high from a transfer until the result is in the output
// register; the next item is taken while that result waits on rsp_stall.
module median_zscore_ewma_conditioner
   import mzec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_throughput_sample,
   input  logic [23:0] req_rtt_sample,
   input  logic [23:0] req_jitter_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_smooth_throughput,
   output logic [23:0] rsp_smooth_rtt,
   output logic [23:0] rsp_smooth_jitter,
   output logic        rsp_throughput_rejected,
   output logic        rsp_rtt_rejected,
   output logic        rsp_jitter_rejected,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_data
);

   typedef enum logic [4:0] {
      S_IDLE, S_PUSH, S_SCAN, S_READ, S_SQ, S_WAIT, S_SQACC, S_TVAL, S_NSQ,
      S_SS, S_NT, S_DD, S_ZZ, S_RHS, S_EWMA, S_AX, S_BL, S_NEXT, S_OUT
   } state_type;

   state_type         state_ff, ret_ff;
   logic [1:0]        k_ff;
   logic [FILL_W-1:0] i_ff;

   logic [4:0]        win_ff   [3];
   logic [16:0]       gain_ff  [3];
   logic [15:0]       z_ff;
   logic [IDX_W-1:0]  head_ff  [3];
   logic [FILL_W-1:0] fill_ff  [3];
   logic [LVL_W-1:0]  level_ff [3];

   logic [SMP_W-1:0]  mem [4*WIN_MAX];
   logic [SMP_W-1:0]  rdata_ff;

   logic [31:0]       tp_ff;
   logic [23:0]       rtt_ff, jit_ff;
   logic [35:0]       sum_ff;
   logic [67:0]       sq_ff;
   logic [SMP_W:0]    t_ff;
   logic [71:0]       nsq_ff, var_ff;
   logic [75:0]       lhs_ff;
   logic [65:0]       ax_ff;
   logic [2:0]        rej_ff;

   logic              rsp_valid_ff;
   logic [31:0]       out_tp_ff;
   logic [23:0]       out_rtt_ff, out_jit_ff;
   logic [2:0]        out_rej_ff;

   mul_req_type       mreq;
   sort_req_type      sreq;
   logic              mul_done;
   logic [MP_W-1:0]   prod;
   logic [SMP_W:0]    twice_med;

   logic [FILL_W-1:0] n;
   logic [4:0]        win_c;
   logic [IDX_W-1:0]  head_c;
   logic [FILL_W-1:0] fill_c;
   logic [SMP_W-1:0]  smp_c;
   logic [16:0]       alpha_c, oma_c;
   logic [SMP_W:0]    t_c;
   logic [37:0]       nt_c, s2_c, d_c;
   logic [LVL_W-1:0]  x_c;
   logic [66:0]       blend_c;
   logic              out_free;

   mzec_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .done  (mul_done),
      .prod  (prod)
   );

   mzec_sort u_sort (
      .clock        (clock),
      .reset        (reset),
      .req          (sreq),
      .n            (n),
      .twice_median (twice_med)
   );

   assign n = fill_ff[k_ff];

   always_comb begin
      if (win_ff[k_ff] == 5'd0) begin
         win_c = 5'd1;
      end else if (win_ff[k_ff] > 5'(WIN_MAX)) begin
         win_c = 5'(WIN_MAX);
      end else begin
         win_c = win_ff[k_ff];
      end
      // drop the oldest entries so the new sample fits the window
      if (fill_ff[k_ff] >= FILL_W'(win_c)) begin
         head_c = head_ff[k_ff] + IDX_W'(fill_ff[k_ff] - FILL_W'(win_c) + 1'b1);
         fill_c = FILL_W'(win_c) - 1'b1;
      end else begin
         head_c = head_ff[k_ff];
         fill_c = fill_ff[k_ff];
      end
      case (k_ff)
         2'd0:    smp_c = tp_ff;
         2'd1:    smp_c = {8'd0, rtt_ff};
         default: smp_c = {8'd0, jit_ff};
      endcase
      if (gain_ff[k_ff] == 17'd0) begin
         alpha_c = 17'd655;
      end else if (gain_ff[k_ff] > 17'd65536) begin
         alpha_c = 17'd65536;
      end else begin
         alpha_c = gain_ff[k_ff];
      end
      oma_c = 17'd65536 - alpha_c;
      t_c   = (k_ff == 2'd0) ? {tp_ff, 1'b0} : twice_med;
      nt_c  = prod[37:0];
      s2_c  = {1'b0, sum_ff, 1'b0};
      d_c   = (nt_c > s2_c) ? nt_c - s2_c : s2_c - nt_c;
      x_c   = (k_ff == 2'd0) ? {tp_ff, 16'd0} : {8'd0, t_ff[24:0], 15'd0};
      blend_c = {1'b0, ax_ff} + prod[66:0] + 67'd32768;
   end

   always_comb begin
      mreq  = '0;
      sreq  = '0;
      sreq.x = rdata_ff;
      case (state_ff)
         S_SCAN: sreq.clear = 1'b1;
         S_SQ: begin
            sreq.insert = 1'b1;
            mreq = '{1'b1, {40'd0, rdata_ff}, {rdata_ff, 8'd0}, 4'd8};
         end
         S_TVAL: mreq = '{1'b1, {4'd0, sq_ff}, {3'd0, n, 32'd0}, 4'd2};
         S_NSQ:  mreq = '{1'b1, {36'd0, sum_ff}, {sum_ff, 4'd0}, 4'd9};
         S_SS:   mreq = '{1'b1, {39'd0, t_ff}, {3'd0, n, 32'd0}, 4'd2};
         S_NT:   mreq = '{1'b1, {34'd0, d_c}, {2'd0, d_c}, 4'd10};
         S_DD:   mreq = '{1'b1, {56'd0, z_ff}, {z_ff, 24'd0}, 4'd4};
         S_ZZ:   mreq = '{1'b1, var_ff, {2'd0, prod[31:0], 2'd0, 4'd0}, 4'd9};
         S_EWMA: mreq = '{1'b1, {24'd0, x_c}, {3'd0, alpha_c, 20'd0}, 4'd5};
         S_AX:   mreq = '{1'b1, {24'd0, level_ff[k_ff]}, {3'd0, oma_c, 20'd0}, 4'd5};
         default: mreq = '0;
      endcase
      // abandon the unused launches
      if (state_ff == S_TVAL && n < FILL_W'(3)) mreq.start = 1'b0;
      if (state_ff == S_SS && nsq_ff <= prod[71:0]) mreq.start = 1'b0;
      if (state_ff == S_EWMA && (rej_ff[k_ff] || level_ff[k_ff] == '0)) begin
         mreq.start = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 3; c++) begin
            win_ff[c]  <= 5'd5;
            gain_ff[c] <= 17'd19661;
         end
         z_ff <= 16'd768;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_TP_WIN:   win_ff[0]  <= csr_data[4:0];
            REG_RTT_WIN:  win_ff[1]  <= csr_data[4:0];
            REG_JIT_WIN:  win_ff[2]  <= csr_data[4:0];
            REG_Z_LIMIT:  z_ff       <= csr_data[15:0];
            REG_TP_GAIN:  gain_ff[0] <= csr_data;
            REG_RTT_GAIN: gain_ff[1] <= csr_data;
            REG_JIT_GAIN: gain_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_PUSH) begin
         mem[{k_ff, head_c + IDX_W'(fill_c)}] <= smp_c;
      end
      rdata_ff <= mem[{k_ff, head_ff[k_ff] + i_ff[IDX_W-1:0]}];
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < 3; c++) begin
            head_ff[c]  <= '0;
            fill_ff[c]  <= '0;
            level_ff[c] <= '0;
         end
      end else begin
         // in S_OUT the output register is reloaded or held below
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  tp_ff    <= req_throughput_sample;
                  rtt_ff   <= req_rtt_sample;
                  jit_ff   <= req_jitter_sample;
                  k_ff     <= 2'd0;
                  state_ff <= S_PUSH;
               end
            end
            S_PUSH: begin
               head_ff[k_ff] <= head_c;
               fill_ff[k_ff] <= fill_c + 1'b1;
               if (k_ff == 2'd2) begin
                  k_ff     <= 2'd0;
                  state_ff <= S_SCAN;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            S_SCAN: begin
               sum_ff   <= '0;
               sq_ff    <= '0;
               i_ff     <= '0;
               state_ff <= S_READ;
            end
            S_READ: state_ff <= S_SQ;
            S_SQ: begin
               sum_ff   <= sum_ff + {4'd0, rdata_ff};
               ret_ff   <= S_SQACC;
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (mul_done) state_ff <= ret_ff;
            end
            S_SQACC: begin
               sq_ff <= sq_ff + prod[67:0];
               i_ff  <= i_ff + 1'b1;
               state_ff <= (i_ff + 1'b1 == n) ? S_TVAL : S_READ;
            end
            S_TVAL: begin
               t_ff        <= t_c;
               rej_ff[k_ff] <= 1'b0;
               if (n < FILL_W'(3)) begin
                  state_ff <= S_EWMA;
               end else begin
                  ret_ff   <= S_NSQ;
                  state_ff <= S_WAIT;
               end
            end
            S_NSQ: begin
               nsq_ff   <= prod[71:0];
               ret_ff   <= S_SS;
               state_ff <= S_WAIT;
            end
            S_SS: begin
               if (nsq_ff <= prod[71:0]) begin
                  state_ff <= S_EWMA;
               end else begin
                  var_ff   <= nsq_ff - prod[71:0];
                  ret_ff   <= S_NT;
                  state_ff <= S_WAIT;
               end
            end
            S_NT: begin
               ret_ff   <= S_DD;
               state_ff <= S_WAIT;
            end
            S_DD: begin
               lhs_ff   <= prod[75:0];
               ret_ff   <= S_ZZ;
               state_ff <= S_WAIT;
            end
            S_ZZ: begin
               ret_ff   <= S_RHS;
               state_ff <= S_WAIT;
            end
            S_RHS: begin
               rej_ff[k_ff] <= {20'd0, lhs_ff, 16'd0} > prod;
               state_ff     <= S_EWMA;
            end
            S_EWMA: begin
               if (rej_ff[k_ff]) begin
                  state_ff <= S_NEXT;
               end else if (level_ff[k_ff] == '0) begin
                  level_ff[k_ff] <= x_c;
                  state_ff       <= S_NEXT;
               end else begin
                  ret_ff   <= S_AX;
                  state_ff <= S_WAIT;
               end
            end
            S_AX: begin
               ax_ff    <= prod[65:0];
               ret_ff   <= S_BL;
               state_ff <= S_WAIT;
            end
            S_BL: begin
               level_ff[k_ff] <= blend_c[63:16];
               state_ff       <= S_NEXT;
            end
            S_NEXT: begin
               if (k_ff == 2'd2) begin
                  state_ff <= S_OUT;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_SCAN;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  out_tp_ff    <= level_ff[0][47:16];
                  out_rtt_ff   <= level_ff[1][39:16];
                  out_jit_ff   <= level_ff[2][39:16];
                  out_rej_ff   <= rej_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall               = state_ff != S_IDLE;
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_smooth_throughput   = out_tp_ff;
   assign rsp_smooth_rtt          = out_rtt_ff;
   assign rsp_smooth_jitter       = out_jit_ff;
   assign rsp_throughput_rejected = out_rej_ff[0];
   assign rsp_rtt_rejected        = out_rej_ff[1];
   assign rsp_jitter_rejected     = out_rej_ff[2];

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while an item is in flight");

   a_done_only_waiting: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == S_WAIT)
      else $error("multiplier finished with nobody waiting");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff[0] <= FILL_W'(WIN_MAX) && fill_ff[1] <= FILL_W'(WIN_MAX)
      && fill_ff[2] <= FILL_W'(WIN_MAX))
      else $error("window fill beyond capacity");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && rsp_stall) |=> state_ff == S_OUT)
      else $error("result overwritten before transfer");

endmodule
